### rtl/core/ddo_pkg.sv
// Package with the constants, the arctangent table and the result type for the odometry block.
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int AtanEntries = 24;
  localparam int CordicStepsDefault = 16;
  localparam logic [15:0] RecipReset = 16'd13793;
  localparam logic signed [17:0] PiQ13 = 18'sd25736;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;

  // Bias of 64 turns plus pi that lifts any heading sum above zero, and 2^32 / (2*pi in
  // Q3.13) rounded down, used to estimate how many turns to take off.
  localparam logic signed [23:0] WrapBiasQ13 = 24'sd3319944;
  localparam logic [16:0] TwoPiRecipQ32 = 17'd83442;

  // Input item kinds.
  localparam logic KindSample = 1'b0;
  localparam logic KindPoseSet = 1'b1;

  // Rounded arctangent of 2^-i in Q.16.
  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] r;
    case (idx)
      5'd0: r = 17'd51472;
      5'd1: r = 17'd30386;
      5'd2: r = 17'd16055;
      5'd3: r = 17'd8150;
      5'd4: r = 17'd4091;
      5'd5: r = 17'd2047;
      5'd6: r = 17'd1024;
      5'd7: r = 17'd512;
      5'd8: r = 17'd256;
      5'd9: r = 17'd128;
      5'd10: r = 17'd64;
      5'd11: r = 17'd32;
      5'd12: r = 17'd16;
      5'd13: r = 17'd8;
      5'd14: r = 17'd4;
      5'd15: r = 17'd2;
      5'd16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // Bring a heading into [-pi, pi); the input lies within two turns of that range.
  function automatic logic signed [15:0] wrap_heading(input logic signed [17:0] a);
    logic signed [17:0] t;
    t = a;
    if (t >= PiQ13) t = t - TwoPiQ13;
    if (t >= PiQ13) t = t - TwoPiQ13;
    if (t < -PiQ13) t = t + TwoPiQ13;
    if (t < -PiQ13) t = t + TwoPiQ13;
    return t[15:0];
  endfunction

  // Finish the reduction of a biased heading sum u, given the turn count q estimated from
  // the reciprocal product. The estimate is exact or one short, so one correction suffices.
  function automatic logic signed [15:0] reduce_heading(input logic [23:0] u,
                                                        input logic [6:0] q);
    logic [23:0] r;
    logic signed [16:0] t;
    r = u - 24'(q) * 24'(TwoPiQ13);
    if (r >= 24'(TwoPiQ13)) r = r - 24'(TwoPiQ13);
    t = 17'(r) - 17'(PiQ13);
    return t[15:0];
  endfunction

  typedef struct packed {
    logic               is_reply;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] heading;
    logic signed [15:0] linear_speed;
    logic signed [31:0] angular_speed;
    logic               update_success;
  } ddo_result_t;

endpackage

### rtl/core/ddo_if.sv
// Valid/ready channel interfaces for the odometry input and result items.
`timescale 1ns / 1ps
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] right_speed;
  logic signed [15:0] left_speed;
  logic [15:0]        step_time;
  logic               set_x_enable;
  logic               set_y_enable;
  logic               set_heading_enable;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [15:0] new_heading;
  modport source (output valid, kind, right_speed, left_speed, step_time, set_x_enable,
                  set_y_enable, set_heading_enable, new_x, new_y, new_heading,
                  input ready);
  modport sink (input valid, kind, right_speed, left_speed, step_time, set_x_enable,
                set_y_enable, set_heading_enable, new_x, new_y, new_heading,
                output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic               is_reply;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] heading;
  logic signed [15:0] linear_speed;
  logic signed [31:0] angular_speed;
  logic               update_success;
  modport source (output valid, is_reply, pose_x, pose_y, heading, linear_speed,
                  angular_speed, update_success, input ready);
  modport sink (input valid, is_reply, pose_x, pose_y, heading, linear_speed,
                angular_speed, update_success, output ready);
endinterface

### rtl/core/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine in Q4.30, one step per cycle.
`timescale 1ns / 1ps
module ddo_cordic #(
  parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [15:0]  angle,
  output logic                done,
  output logic signed [33:0]  cos_out,
  output logic signed [33:0]  sin_out
);
  import ddo_pkg::*;

  localparam int Steps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [20:0] z_r, z_nxt;
  logic [4:0]         i_r, i_nxt;
  logic               busy_r, busy_nxt, flip_r, flip_nxt, done_r, done_nxt;
  logic signed [20:0] z0;

  // Fold the angle into [-pi/2, pi/2] and step the rotation.
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    z0 = {{2{angle[15]}}, angle, 3'b000};
    if (start) begin
      flip_nxt = 1'b0;
      if (z0 > 21'(HalfPiQ16)) begin
        z0 = z0 - 21'(PiQ16);
        flip_nxt = 1'b1;
      end else if (z0 < -21'(HalfPiQ16)) begin
        z0 = z0 + 21'(PiQ16);
        flip_nxt = 1'b1;
      end
      x_nxt = CordicGainQ30;
      y_nxt = '0;
      z_nxt = z0;
      i_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[20]) begin
        x_nxt = x_r - (y_r >>> i_r);
        y_nxt = y_r + (x_r >>> i_r);
        z_nxt = z_r - 21'(atan_q16(i_r));
      end else begin
        x_nxt = x_r + (y_r >>> i_r);
        y_nxt = y_r - (x_r >>> i_r);
        z_nxt = z_r + 21'(atan_q16(i_r));
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(Steps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    flip_r <= flip_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign cos_out = flip_r ? -x_r : x_r;
  assign sin_out = flip_r ? -y_r : y_r;
endmodule

### rtl/core/differential_drive_odometry.sv
// Top level of the differential-drive odometry block: sequencer, multiplier and pose state.
`timescale 1ns / 1ps
// A wheel speed sample runs through the states S_W, S_WDT, S_MQ, S_MR and S_ANG, which form
// w, w*dt and the two heading reductions; the one-step-per-cycle CORDIC then runs in S_COR
// while v*dt is formed, and S_VCX, S_DX and S_DY form and store both position steps, all
// on one shared 34x34 multiplier. Its result valid rises as S_DY stores the last step.
// A pose set raises its reply valid at the transfer edge itself. The input is not ready
// while an item is at work or while its result waits to be taken. The first sample after
// reset only arms the block.
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  ddo_in_if.sink      in_ch,
  ddo_out_if.source   out_ch
);
  import ddo_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_W    = 10'b0000000010, S_WDT  = 10'b0000000100,
    S_MQ   = 10'b0000001000, S_MR   = 10'b0000010000, S_ANG  = 10'b0000100000,
    S_COR  = 10'b0001000000, S_VCX  = 10'b0010000000, S_DX   = 10'b0100000000,
    S_DY   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] recip_r;
  logic signed [31:0] px_r, py_r;
  logic signed [15:0] hd_r;
  logic init_r;
  logic signed [15:0] r_r, l_r, v_r;
  logic [15:0] dt_r;
  logic signed [31:0] w_r;
  logic signed [47:0] wdt_r;
  logic signed [63:0] prod_r;
  logic signed [33:0] cos_r, sin_r;
  logic signed [33:0] vdt_r;
  logic [23:0] u_r;
  logic signed [15:0] mid_r, hdn_r;
  ddo_result_t res_r;
  logic out_valid_r;

  // Shared multiplier operands, chosen by the sequencer.
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic cor_start, cor_done;
  logic signed [33:0] cor_c, cor_s;
  logic signed [31:0] w_now;
  logic signed [23:0] u_mid, u_hd;
  logic [6:0] quo;
  logic signed [32:0] sum_x;
  logic signed [31:0] sat_x;

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;

  // Angular speed from the previous product, biased heading sums and the turn estimate.
  assign w_now = 32'(prod_r >>> 12);
  assign u_mid = 24'(hd_r) + 24'(prod_r >>> 16) + WrapBiasQ13;
  assign u_hd = 24'(hd_r) + 24'(wdt_r >>> 15) + WrapBiasQ13;
  assign quo = prod_r[38:32];

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_W: begin
        ma = 34'($signed({r_r[15], r_r}) - $signed({l_r[15], l_r}));
        mb = 34'($signed({1'b0, recip_r}));
      end
      S_WDT: begin ma = 34'(w_now); mb = 34'($signed({1'b0, dt_r})); end
      S_MQ:  begin ma = 34'(u_mid); mb = 34'($signed({1'b0, TwoPiRecipQ32})); end
      S_MR:  begin ma = 34'(u_hd); mb = 34'($signed({1'b0, TwoPiRecipQ32})); end
      S_COR: begin ma = 34'(v_r); mb = 34'($signed({1'b0, dt_r})); end
      S_VCX: begin ma = vdt_r; mb = cos_r; end
      S_DX:  begin ma = vdt_r; mb = sin_r; end
      default: begin ma = '0; mb = '0; end
    endcase
    mp = 68'(ma) * 68'(mb);
  end

  assign cor_start = (state_r == S_ANG);
  // Position step with saturation to signed 32 bit.
  assign sum_x = 33'(prod_r >>> 42) + 33'(state_r == S_DY ? py_r : px_r);
  assign sat_x = (sum_x > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (sum_x < -33'sh0_8000_0000) ? 32'sh8000_0000 : sum_x[31:0];

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .angle(mid_r),
    .done(cor_done), .cos_out(cor_c), .sin_out(cor_s)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.ready && in_ch.kind == KindSample && init_r)
                state_nxt = S_W;
      S_W:   state_nxt = S_WDT;
      S_WDT: state_nxt = S_MQ;
      S_MQ:  state_nxt = S_MR;
      S_MR:  state_nxt = S_ANG;
      S_ANG: state_nxt = S_COR;
      S_COR: if (cor_done) state_nxt = S_VCX;
      S_VCX: state_nxt = S_DX;
      S_DX:  state_nxt = S_DY;
      S_DY:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mp[63:0];
    if (state_r == S_IDLE && in_ch.valid && in_ch.ready) begin
      r_r <= in_ch.right_speed;
      l_r <= in_ch.left_speed;
      dt_r <= in_ch.step_time;
      v_r <= 16'((17'(in_ch.right_speed) + 17'(in_ch.left_speed)) >>> 1);
    end
    if (state_r == S_WDT) w_r <= w_now;
    // Midpoint and new heading, each reduced with the help of a reciprocal product.
    if (state_r == S_MQ) begin
      wdt_r <= 48'(prod_r);
      u_r <= u_mid;
    end
    if (state_r == S_MR) begin
      mid_r <= reduce_heading(u_r, quo);
      u_r <= u_hd;
    end
    if (state_r == S_ANG) hdn_r <= reduce_heading(u_r, quo);
    if (state_r == S_COR) vdt_r <= mp[33:0];
    if (cor_done) begin
      cos_r <= cor_c;
      sin_r <= cor_s;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      recip_r <= RecipReset;
      px_r <= '0;
      py_r <= '0;
      hd_r <= '0;
      init_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) recip_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      // Pose set and first-sample arming.
      if (state_r == S_IDLE && in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KindPoseSet) begin
          if (in_ch.set_x_enable) px_r <= in_ch.new_x;
          if (in_ch.set_y_enable) py_r <= in_ch.new_y;
          if (in_ch.set_heading_enable) hd_r <= wrap_heading(18'(in_ch.new_heading));
          res_r.is_reply <= 1'b1;
          res_r.update_success <= in_ch.set_x_enable | in_ch.set_y_enable |
                                  in_ch.set_heading_enable;
          res_r.linear_speed <= '0;
          res_r.angular_speed <= '0;
          out_valid_r <= 1'b1;
        end else begin
          init_r <= 1'b1;
        end
      end
      if (state_r == S_DX) px_r <= sat_x;
      if (state_r == S_DY) begin
        py_r <= sat_x;
        hd_r <= hdn_r;
        res_r.is_reply <= 1'b0;
        res_r.update_success <= 1'b0;
        res_r.linear_speed <= v_r;
        res_r.angular_speed <= w_r;
        out_valid_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.is_reply = res_r.is_reply;
  assign out_ch.pose_x = px_r;
  assign out_ch.pose_y = py_r;
  assign out_ch.heading = hd_r;
  assign out_ch.linear_speed = res_r.linear_speed;
  assign out_ch.angular_speed = res_r.angular_speed;
  assign out_ch.update_success = res_r.update_success;
endmodule
